>>> hdl/residual_snr_meter_defines.svh
// assertion macros for the residual snr meter checker
`ifndef RESIDUAL_SNR_METER_DEFINES_SVH
`define RESIDUAL_SNR_METER_DEFINES_SVH

// property checked on every clock edge while out of reset
`define RSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define RSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rsm_pkg.sv
// shared types, constants and the log2 fraction table of the residual snr meter
`timescale 1ns / 1ps

package rsm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESID_W  = 17;
    localparam int SNR_W    = 16;
    localparam int THR_W    = 32;
    localparam int SIG_SQ_W = 31;
    localparam int RES_SQ_W = 33;
    localparam int CFG_IDX_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIG_THR  = 2'd1;

    localparam logic [THR_W-1:0] SYNTH_THR_RST = 32'd1073742;
    localparam logic [THR_W-1:0] ORIG_THR_RST  = 32'd10737418;

    localparam logic signed [SNR_W-1:0] SNR_FAIL = -16'sd20480;
    localparam logic signed [SNR_W-1:0] SNR_MAX  = 16'sd32767;
    localparam logic signed [SNR_W-1:0] SNR_MIN  = -16'sd32768;
    localparam logic signed [8:0]       SNR_SCALE = 9'sd77;

    typedef struct packed {
        logic signed [RESID_W-1:0] residual;
        logic [SIG_SQ_W-1:0]       synth_sq;
        logic [SIG_SQ_W-1:0]       orig_sq;
        logic [RES_SQ_W-1:0]       resid_sq;
        logic                      last;
    } t_job;

    typedef struct packed {
        logic [THR_W-1:0] synth_thr;
        logic [THR_W-1:0] orig_thr;
    } t_cfg;

    typedef logic [7:0] t_frac_tab [256];

    // 8 fraction bits of log2(1 + i/256) by repeated squaring
    function automatic t_frac_tab build_frac_tab();
        t_frac_tab   tab;
        logic [63:0] y;
        logic [7:0]  f;
        for (int i = 0; i < 256; i++) begin
            y = 64'(256 + i) << 22;
            f = '0;
            for (int k = 0; k < 8; k++) begin
                y = (y * y) >> 30;
                f = {f[6:0], 1'b0};
                if (y >= 64'h8000_0000) begin
                    f[0] = 1'b1;
                    y = y >> 1;
                end
            end
            tab[i] = f;
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();

endpackage

>>> hdl/rsm_fifo.sv
// short job queue between the front and back parts of the residual snr meter
`timescale 1ns / 1ps

module rsm_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsm_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output rsm_pkg::t_job o_job
);

    rsm_pkg::t_job                    r_mem [rsm_pkg::FIFO_DEPTH];
    logic [rsm_pkg::FIFO_PTR_W-1:0]   r_wr;
    logic [rsm_pkg::FIFO_PTR_W-1:0]   r_rd;
    logic [rsm_pkg::FIFO_CNT_W-1:0]   r_cnt;
    logic                             do_push;
    logic                             do_pop;

    assign o_full     = (r_cnt == rsm_pkg::FIFO_CNT_W'(rsm_pkg::FIFO_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> hdl/rsm_front.sv
// front part: takes sample requests, forms the residual and the three squares
`timescale 1ns / 1ps

module rsm_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rsm_pkg::SAMPLE_W-1:0]  i_synth_sample,
    input  logic signed [rsm_pkg::SAMPLE_W-1:0]  i_orig_sample,
    input  logic                                 i_frame_last,
    output logic                                 o_push,
    output rsm_pkg::t_job                        o_job,
    input  logic                                 i_full
);

    logic                                r_v;
    logic signed [rsm_pkg::SAMPLE_W-1:0] r_s;
    logic signed [rsm_pkg::SAMPLE_W-1:0] r_o;
    logic                                r_last;
    logic                                load;
    logic signed [rsm_pkg::RESID_W-1:0]  res;
    logic signed [2*rsm_pkg::SAMPLE_W-1:0] s_prod;
    logic signed [2*rsm_pkg::SAMPLE_W-1:0] o_prod;
    logic signed [2*rsm_pkg::RESID_W-1:0]  r_prod;

    assign load    = !r_v || !i_full;
    assign o_stall = r_v && i_full;
    assign o_push  = r_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_s    <= i_synth_sample;
            r_o    <= i_orig_sample;
            r_last <= i_frame_last;
        end
    end

    always_comb begin
        res    = rsm_pkg::RESID_W'(r_s) - rsm_pkg::RESID_W'(r_o);
        s_prod = r_s * r_s;
        o_prod = r_o * r_o;
        r_prod = res * res;
        o_job.residual = res;
        o_job.synth_sq = s_prod[rsm_pkg::SIG_SQ_W-1:0];
        o_job.orig_sq  = o_prod[rsm_pkg::SIG_SQ_W-1:0];
        o_job.resid_sq = r_prod[rsm_pkg::RES_SQ_W-1:0];
        o_job.last     = r_last;
    end

endmodule

>>> hdl/rsm_back.sv
// back part: energy accumulation, threshold test and log10 ratio pipeline
`timescale 1ns / 1ps

module rsm_back #(
    parameter int FRAME_LOG2_MAX = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rsm_pkg::t_cfg                       i_cfg,
    input  logic                                i_job_valid,
    input  rsm_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rsm_pkg::RESID_W-1:0]  o_residual,
    output logic signed [rsm_pkg::SNR_W-1:0]    o_snr_log,
    output logic                                o_snr_valid
);

    localparam int SIG_W = 31 + FRAME_LOG2_MAX;
    localparam int RES_W = 33 + FRAME_LOG2_MAX;
    localparam int N_GRP = (RES_W + 7) / 8;
    localparam int PAD_W = N_GRP * 8;
    localparam int GRP_W = $clog2(N_GRP);
    localparam int POS_W = GRP_W + 3;
    localparam int LG_W  = POS_W + 8;
    localparam int D_W   = LG_W + 1;
    localparam int V_W   = D_W + 9;

    // highest 8-bit group that holds a one
    function automatic logic [GRP_W-1:0] lead_grp(input logic [PAD_W-1:0] e);
        logic [GRP_W-1:0] g;
        g = '0;
        for (int k = 0; k < N_GRP; k++) begin
            if (|e[k*8 +: 8]) begin
                g = GRP_W'(k);
            end
        end
        return g;
    endfunction

    // leading-one position and the 8 bits below it, zeros filled below bit 0
    function automatic logic [POS_W+7:0] pos_idx(input logic [PAD_W-1:0] e,
                                                 input logic [GRP_W-1:0] g);
        logic [PAD_W+7:0] ext;
        logic [15:0]      w;
        logic [2:0]       f;
        ext = {e, 8'b0};
        w   = ext[{g, 3'b000} +: 16];
        f   = '0;
        for (int k = 0; k < 8; k++) begin
            if (w[8+k]) begin
                f = 3'(k);
            end
        end
        return {g, f, w[f +: 8]};
    endfunction

    logic adv;

    // accumulators
    logic [SIG_W-1:0] r_se, r_oe;
    logic [RES_W-1:0] r_re;
    logic [SIG_W:0]   s_sum, o_sum;
    logic [RES_W:0]   r_sum;
    logic [SIG_W-1:0] s_sat, o_sat;
    logic [RES_W-1:0] r_sat;

    // stage valids
    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    // stage 1
    logic signed [rsm_pkg::RESID_W-1:0] r1_res;
    logic                               r1_last;
    logic [SIG_W-1:0]                   r1_se, r1_oe;
    logic [RES_W-1:0]                   r1_re;

    // stage 2
    logic signed [rsm_pkg::RESID_W-1:0] r2_res;
    logic                               r2_last;
    logic                               r2_fail;
    logic [PAD_W-1:0]                   r2_oe, r2_re;
    logic [GRP_W-1:0]                   r2_go, r2_gr;

    // stage 3
    logic signed [rsm_pkg::RESID_W-1:0] r3_res;
    logic                               r3_last;
    logic                               r3_fail;
    logic [POS_W+7:0]                   r3_lo, r3_lr;

    // stage 4
    logic signed [rsm_pkg::RESID_W-1:0] r4_res;
    logic                               r4_last;
    logic                               r4_fail;
    logic signed [D_W-1:0]              r4_d;

    // stage 5 is the output register
    logic signed [rsm_pkg::RESID_W-1:0] r5_res;
    logic signed [rsm_pkg::SNR_W-1:0]   r5_snr;
    logic                               r5_last;

    logic                     fail;
    logic [LG_W-1:0]          log_o, log_r;
    logic signed [V_W-1:0]    v;
    logic signed [31:0]       q;
    logic signed [rsm_pkg::SNR_W-1:0] n_snr;

    assign adv   = !r5_v || !i_stall;
    assign o_pop = i_job_valid && adv;

    always_comb begin
        s_sum = {1'b0, r_se} + (SIG_W + 1)'(i_job.synth_sq);
        o_sum = {1'b0, r_oe} + (SIG_W + 1)'(i_job.orig_sq);
        r_sum = {1'b0, r_re} + (RES_W + 1)'(i_job.resid_sq);
        s_sat = s_sum[SIG_W] ? {SIG_W{1'b1}} : s_sum[SIG_W-1:0];
        o_sat = o_sum[SIG_W] ? {SIG_W{1'b1}} : o_sum[SIG_W-1:0];
        r_sat = r_sum[RES_W] ? {RES_W{1'b1}} : r_sum[RES_W-1:0];
    end

    assign fail = !((r1_se > SIG_W'(i_cfg.synth_thr)) && (r1_oe > SIG_W'(i_cfg.orig_thr)));

    assign log_o = {r3_lo[POS_W+7:8], rsm_pkg::FRAC_TAB[r3_lo[7:0]]};
    assign log_r = {r3_lr[POS_W+7:8], rsm_pkg::FRAC_TAB[r3_lr[7:0]]};

    always_comb begin
        v = V_W'(r4_d) * V_W'(rsm_pkg::SNR_SCALE);
        // arithmetic shift gives the floor for negative values too
        q = 32'(v >>> 8);
        if (!r4_last) begin
            n_snr = '0;
        end else if (r4_fail) begin
            n_snr = rsm_pkg::SNR_FAIL;
        end else if (q > 32'(rsm_pkg::SNR_MAX)) begin
            n_snr = rsm_pkg::SNR_MAX;
        end else if (q < 32'(rsm_pkg::SNR_MIN)) begin
            n_snr = rsm_pkg::SNR_MIN;
        end else begin
            n_snr = q[rsm_pkg::SNR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se <= '0;
            r_oe <= '0;
            r_re <= '0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (adv) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            if (o_pop) begin
                // frame end clears, with this request's squares already reported
                r_se <= i_job.last ? '0 : s_sat;
                r_oe <= i_job.last ? '0 : o_sat;
                r_re <= i_job.last ? '0 : r_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_res  <= i_job.residual;
            r1_last <= i_job.last;
            r1_se   <= s_sat;
            r1_oe   <= o_sat;
            r1_re   <= r_sat;

            r2_res  <= r1_res;
            r2_last <= r1_last;
            r2_fail <= fail;
            r2_oe   <= PAD_W'(r1_oe);
            r2_re   <= PAD_W'(r1_re);
            r2_go   <= lead_grp(PAD_W'(r1_oe));
            r2_gr   <= lead_grp(PAD_W'(r1_re));

            r3_res  <= r2_res;
            r3_last <= r2_last;
            r3_fail <= r2_fail;
            r3_lo   <= pos_idx(r2_oe, r2_go);
            r3_lr   <= pos_idx(r2_re, r2_gr);

            r4_res  <= r3_res;
            r4_last <= r3_last;
            r4_fail <= r3_fail;
            r4_d    <= $signed({1'b0, log_o}) - $signed({1'b0, log_r});

            r5_res  <= r4_res;
            r5_last <= r4_last;
            r5_snr  <= n_snr;
        end
    end

    assign o_valid     = r5_v;
    assign o_residual  = r5_res;
    assign o_snr_log   = r5_snr;
    assign o_snr_valid = r5_last;

endmodule

>>> hdl/residual_snr_meter.sv
// Residual and log10 signal-to-residual ratio meter, one sample pair per cycle while the output is not stalled.
// A result passes the front register, the queue, then the accumulate, leading-group search,
// fine position, log difference and scale registers.
// Reset (synchronous, active low) empties the queue and pipeline, clears the
// energies and loads the default thresholds.
`timescale 1ns / 1ps

module residual_snr_meter #(
    parameter int FRAME_LOG2_MAX = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsm_pkg::THR_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rsm_pkg::SAMPLE_W-1:0] i_synth_sample,
    input  logic signed [rsm_pkg::SAMPLE_W-1:0] i_orig_sample,
    input  logic                                i_frame_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rsm_pkg::RESID_W-1:0]  o_residual,
    output logic signed [rsm_pkg::SNR_W-1:0]    o_snr_log,
    output logic                                o_snr_valid
);

    rsm_pkg::t_cfg r_cfg;
    rsm_pkg::t_job push_job;
    rsm_pkg::t_job pop_job;
    logic          push;
    logic          pop;
    logic          full;
    logic          nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.synth_thr <= rsm_pkg::SYNTH_THR_RST;
            r_cfg.orig_thr  <= rsm_pkg::ORIG_THR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rsm_pkg::CFG_SYNTH_THR) begin
                r_cfg.synth_thr <= i_cfg_data;
            end
            if (i_cfg_index == rsm_pkg::CFG_ORIG_THR) begin
                r_cfg.orig_thr <= i_cfg_data;
            end
        end
    end

    rsm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_synth_sample (i_synth_sample),
        .i_orig_sample  (i_orig_sample),
        .i_frame_last   (i_frame_last),
        .o_push         (push),
        .o_job          (push_job),
        .i_full         (full)
    );

    rsm_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_job      (pop_job)
    );

    rsm_back #(
        .FRAME_LOG2_MAX (FRAME_LOG2_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (nonempty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_residual  (o_residual),
        .o_snr_log   (o_snr_log),
        .o_snr_valid (o_snr_valid)
    );

endmodule

>>> hdl/rsm_checker.sv
// port-level checks for the residual snr meter, bound to the top level
`timescale 1ns / 1ps
`include "residual_snr_meter_defines.svh"

module rsm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [rsm_pkg::RESID_W-1:0] o_residual,
    input logic signed [rsm_pkg::SNR_W-1:0]   o_snr_log,
    input logic                               o_snr_valid
);

    logic                                         mid_frame;
    logic                                         frame_end;
    logic                                         snr_ok;
    logic                                         held;
    logic [rsm_pkg::RESID_W+rsm_pkg::SNR_W+1:0]   out_bus;

    assign mid_frame = o_valid && !o_snr_valid;
    assign frame_end = o_valid && o_snr_valid;
    // frame ratio is either the failure code or a plausible log value
    assign snr_ok    = (o_snr_log == rsm_pkg::SNR_FAIL)
                       || (o_snr_log > -16'sd4096 && o_snr_log < 16'sd4096);
    assign held      = o_valid && i_stall;
    assign out_bus   = {o_valid, o_residual, o_snr_log, o_snr_valid};

    // pipeline and front register come out of reset empty
    `RSM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "busy after reset")

    // mid-frame results carry a zero ratio
    `RSM_ASSERT(a_mid_zero, i_clk, i_rst_n, mid_frame |-> o_snr_log == '0, "snr set mid-frame")

    `RSM_ASSERT(a_snr_range, i_clk, i_rst_n, frame_end |-> snr_ok, "snr out of range")

    `RSM_ASSERT(a_out_hold, i_clk, i_rst_n, held |=> $stable(out_bus), "stalled result changed")

endmodule

bind residual_snr_meter rsm_checker u_rsm_checker (.*);

>>> dv/residual_snr_meter_tb.sv
// self-checking testbench for the residual snr meter: residual, frame energies and log10 ratio
`timescale 1ns / 1ps

module residual_snr_meter_tb;

    import rsm_pkg::*;

    localparam int FRAME_LOG2_MAX = 12;
    localparam int SIG_ACC_W      = SIG_SQ_W + FRAME_LOG2_MAX;
    localparam int RES_ACC_W      = RES_SQ_W + FRAME_LOG2_MAX;
    localparam int FULL_SCALE_LEN = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_PRINTED    = 40;

    // indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {MIX_NOISE, MIX_CLOSE, MIX_EQUAL, MIX_QUIET, MIX_SILENT_ORIG} t_frame_mix;

    typedef struct {
        logic signed [RESID_W-1:0] residual;
        logic signed [SNR_W-1:0]   snr_log;
        logic                      snr_valid;
    } t_meter_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [THR_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_synth_sample;
    logic signed [SAMPLE_W-1:0] i_orig_sample;
    logic                       i_frame_last;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [RESID_W-1:0]  o_residual;
    logic signed [SNR_W-1:0]    o_snr_log;
    logic                       o_snr_valid;

    // energy and threshold state of the prediction
    logic [SIG_ACC_W-1:0] acc_synth;
    logic [SIG_ACC_W-1:0] acc_orig;
    logic [RES_ACC_W-1:0] acc_resid;
    logic [THR_W-1:0]     thr_synth;
    logic [THR_W-1:0]     thr_orig;

    t_meter_result pending_results[$];

    bit no_idle;
    bit hold_rx;
    int fail_count;
    int pairs_sent;
    int frames_sent;
    int below_thr_count;
    int settings_count;
    int results_checked;

    residual_snr_meter #(
        .FRAME_LOG2_MAX(FRAME_LOG2_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_synth_sample(i_synth_sample),
        .i_orig_sample (i_orig_sample),
        .i_frame_last  (i_frame_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_residual    (o_residual),
        .o_snr_log     (o_snr_log),
        .o_snr_valid   (o_snr_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still pending", pending_results.size());
        $display("** residual_snr_meter: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // fraction bits of log2(1 + m/256), one bit per squaring
    function automatic logic [7:0] log2_frac(input logic [7:0] m);
        logic [63:0] y;
        logic [7:0]  f;
        y = 64'({1'b1, m}) << 22;
        f = '0;
        for (int k = 0; k < 8; k++) begin
            y = (y * y) >> 30;
            f = {f[6:0], 1'b0};
            if (y >= 64'h8000_0000) begin
                f[0] = 1'b1;
                y = y >> 1;
            end
        end
        return f;
    endfunction

    function automatic int log2_q8(input logic [63:0] e);
        int          p;
        logic [63:0] m;
        if (e == 0)
            e = 64'd1;  // empty energy counts as one lsb
        p = 0;
        for (int b = 0; b < 64; b++)
            if (e[b])
                p = b;
        m = (p >= 8) ? (e >> (p - 8)) : (e << (8 - p));
        return p * 256 + int'(log2_frac(m[7:0]));
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] add,
                                            input int bits);
        logic [63:0] top;
        top = (64'd1 << bits) - 64'd1;
        acc = acc + add;
        return (acc > top) ? top : acc;
    endfunction

    function automatic logic signed [SNR_W-1:0] frame_snr();
        longint q;
        if (acc_synth <= thr_synth || acc_orig <= thr_orig) begin
            below_thr_count++;
            return SNR_FAIL;
        end
        q = longint'(log2_q8(64'(acc_orig)) - log2_q8(64'(acc_resid))) * longint'(SNR_SCALE);
        q = q >>> 8;  // floor toward minus infinity
        if (q > SNR_MAX)
            q = SNR_MAX;
        if (q < SNR_MIN)
            q = SNR_MIN;
        return SNR_W'(q);
    endfunction

    function automatic t_meter_result predict_meter(input logic signed [SAMPLE_W-1:0] synth,
                                                    input logic signed [SAMPLE_W-1:0] orig,
                                                    input logic last);
        t_meter_result r;
        longint        s;
        longint        o;
        longint        d;
        s = synth;
        o = orig;
        d = s - o;
        acc_synth = SIG_ACC_W'(sat_add(64'(acc_synth), s * s, SIG_ACC_W));
        acc_orig  = SIG_ACC_W'(sat_add(64'(acc_orig), o * o, SIG_ACC_W));
        acc_resid = RES_ACC_W'(sat_add(64'(acc_resid), d * d, RES_ACC_W));
        r.residual  = RESID_W'(d);
        r.snr_log   = '0;
        r.snr_valid = last;
        if (last) begin
            r.snr_log = frame_snr();
            acc_synth = '0;
            acc_orig  = '0;
            acc_resid = '0;
            frames_sent++;
        end
        return r;
    endfunction

    task automatic send_pair(input logic signed [SAMPLE_W-1:0] synth,
                             input logic signed [SAMPLE_W-1:0] orig, input logic last);
        while (!no_idle && $urandom_range(99) < 14) begin
            i_valid        <= 1'b0;
            i_synth_sample <= SAMPLE_W'($urandom);
            i_orig_sample  <= SAMPLE_W'($urandom);
            i_frame_last   <= 1'($urandom);
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_synth_sample <= synth;
        i_orig_sample  <= orig;
        i_frame_last   <= last;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_meter(synth, orig, last));
        pairs_sent++;
    endtask

    task automatic send_frame(input int len, input t_frame_mix mix);
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] o;
        for (int n = 0; n < len; n++) begin
            s = SAMPLE_W'($urandom);
            o = SAMPLE_W'($urandom);
            case (mix)
                MIX_CLOSE:       s = o + SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
                MIX_EQUAL:       s = o;
                MIX_QUIET: begin
                    s = SAMPLE_W'($urandom_range(0, 2047)) - 16'sd1024;
                    o = SAMPLE_W'($urandom_range(0, 2047)) - 16'sd1024;
                end
                MIX_SILENT_ORIG: o = '0;
                default: ;
            endcase
            send_pair(s, o, n == len - 1);
        end
    endtask

    // every result back before anything touches the registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_SYNTH_THR)
            thr_synth = data;
        else if (idx == CFG_ORIG_THR)
            thr_orig = data;
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] synth, input logic [THR_W-1:0] orig);
        wait_idle();
        write_reg(CFG_SYNTH_THR, synth);
        write_reg(CFG_ORIG_THR, orig);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic test_directed();
        // full-scale extremes in one passing frame
        send_pair(32767, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b0);
        send_pair(-32768, -32768, 1'b0);
        send_pair(0, 0, 1'b0);
        send_pair(1, -1, 1'b1);
        send_pair(-32768, 32767, 1'b1);
        // zero residual energy
        send_pair(12345, 12345, 1'b0);
        send_pair(-20000, -20000, 1'b0);
        send_pair(32767, 32767, 1'b1);
        // zero original energy
        send_pair(1000, 0, 1'b0);
        send_pair(-5000, 0, 1'b1);
        // synth energy under its threshold
        send_pair(1, 20000, 1'b0);
        send_pair(0, -20000, 1'b1);
        // orig energy just under, then just over its default threshold
        send_pair(30000, 3000, 1'b1);
        send_pair(30000, 3277, 1'b1);
        // residual of one lsb against a large original gives a high ratio
        send_pair(20000, 20001, 1'b1);
        // writes to unused indexes must not land on a threshold
        wait_idle();
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '1);
        i_cfg_we <= 1'b0;
        send_pair(30000, 3277, 1'b1);
        send_pair(-30000, -3277, 1'b1);
    endtask

    task automatic test_thresholds();
        set_thresholds('0, '0);
        send_frame(6, MIX_NOISE);
        send_frame(4, MIX_SILENT_ORIG);
        send_frame(3, MIX_QUIET);
        send_pair(0, 1, 1'b1);
        send_pair(1, 1, 1'b1);
        set_thresholds('1, '1);
        send_frame(2, MIX_NOISE);
        send_frame(40, MIX_NOISE);
        send_frame(40, MIX_EQUAL);
        // energies equal to a threshold fail, one step above pass
        set_thresholds(32'd4000000, 32'd9000000);
        send_pair(2000, 3000, 1'b1);
        send_pair(2001, 3000, 1'b1);
        send_pair(2000, 3001, 1'b1);
        send_pair(2001, 3001, 1'b1);
        send_pair(-2001, -3001, 1'b1);
        set_thresholds(SYNTH_THR_RST, ORIG_THR_RST);
    endtask

    task automatic test_backpressure();
        hold_rx = 1'b1;
        send_frame(60, MIX_NOISE);
        wait_idle();
        no_idle = 1'b1;
        for (int f = 0; f < 4; f++)
            send_frame($urandom_range(10, 40), MIX_CLOSE);
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        int         sent;
        int         pick;
        int         len;
        t_frame_mix mix;
        sent = 0;
        while (sent < 150) begin
            if ($urandom_range(7) == 0) begin
                pick = $urandom_range(3);
                if (pick == 0)
                    set_thresholds(SYNTH_THR_RST, ORIG_THR_RST);
                else if (pick == 1)
                    set_thresholds($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 25));
                else if (pick == 2)
                    set_thresholds($urandom, $urandom);
                else
                    set_thresholds('0, $urandom_range(0, 1 << 20));
            end
            pick = $urandom_range(99);
            if (pick < 35)
                mix = MIX_NOISE;
            else if (pick < 65)
                mix = MIX_CLOSE;
            else if (pick < 75)
                mix = MIX_EQUAL;
            else if (pick < 90)
                mix = MIX_QUIET;
            else
                mix = MIX_SILENT_ORIG;
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
            send_frame(len, mix);
            sent += len;
        end
        set_thresholds(SYNTH_THR_RST, ORIG_THR_RST);
    endtask

    task automatic test_full_scale();
        // alternating full-scale pairs, largest squares every sample
        for (int n = 0; n < FULL_SCALE_LEN; n++) begin
            if (n[0])
                send_pair(-32768, 32767, n == FULL_SCALE_LEN - 1);
            else
                send_pair(32767, -32768, n == FULL_SCALE_LEN - 1);
        end
        // energies must restart from zero afterwards
        send_frame(5, MIX_CLOSE);
        wait_idle();
    endtask

    // output side stall: random, a quiet stretch, or one long hold
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_rx = 1'b0;
            end
            i_stall <= !no_idle && ($urandom_range(99) < 14);
        end
    end

    always @(posedge i_clk) begin
        t_meter_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_residual !== want.residual)
                    report_mismatch($sformatf("residual got %0d want %0d",
                                              o_residual, want.residual));
                if (o_snr_log !== want.snr_log)
                    report_mismatch($sformatf("snr_log got %0d want %0d",
                                              o_snr_log, want.snr_log));
                if (o_snr_valid !== want.snr_valid)
                    report_mismatch($sformatf("snr_valid got %b want %b",
                                              o_snr_valid, want.snr_valid));
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_SYNTH_THR;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_synth_sample <= '0;
        i_orig_sample  <= '0;
        i_frame_last   <= 1'b0;
        acc_synth = '0;
        acc_orig  = '0;
        acc_resid = '0;
        thr_synth = SYNTH_THR_RST;
        thr_orig  = ORIG_THR_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_thresholds();
        test_backpressure();
        test_random();
        test_full_scale();

        i_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", pending_results.size()));

        $display("checked %0d results for %0d sample pairs in %0d frames, %0d below threshold",
                 results_checked, pairs_sent, frames_sent, below_thr_count);
        $display("used %0d threshold settings, a %0d-sample full-scale frame, a %0d-cycle hold",
                 settings_count, FULL_SCALE_LEN, HOLD_CYCLES);
        if (fail_count == 0)
            $display("** residual_snr_meter: PASSED **");
        else
            $display("** residual_snr_meter: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/rsm_pkg.sv
hdl/rsm_fifo.sv
hdl/rsm_front.sv
hdl/rsm_back.sv
hdl/residual_snr_meter.sv
hdl/rsm_checker.sv
dv/residual_snr_meter_tb.sv
